[hdl/servo_gain_autotune_fsm_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the servo gain auto-tuner
// Concurrent checks in simulation; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef SERVO_GAIN_AUTOTUNE_FSM_DEFINES_SVH
`define SERVO_GAIN_AUTOTUNE_FSM_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication under synchronous reset
`define SGAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgat assertion failed");

// next-cycle implication under synchronous reset
`define SGAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgat assertion failed");

`else

`define SGAT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SGAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/sgat_pkg.sv]
// ----------------------------------------------------------------------------
// sgat_pkg
// Types, constants and helpers shared by the servo gain auto-tuner.
// ----------------------------------------------------------------------------
`default_nettype none

package sgat_pkg;

  localparam int GAIN_W  = 16;
  localparam int TIMER_W = 16;
  localparam int POS_W   = 32;
  localparam int ERR_W   = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
  localparam logic [ERR_W-1:0]   ERR_MAX   = '1;

  localparam logic [GAIN_W-1:0] KP_STEP     = GAIN_W'(20);
  localparam logic [GAIN_W-1:0] KD_STEP_OSC = GAIN_W'(20);
  localparam logic [GAIN_W-1:0] KD_STEP_UP  = GAIN_W'(10);
  localparam logic [GAIN_W-1:0] KP_BACKOFF  = GAIN_W'(20);

  // register values after reset
  localparam logic [POS_W-1:0]   RST_STEP_AMP = POS_W'(1000);
  localparam logic [TIMER_W-1:0] RST_WAIT     = TIMER_W'(1000);
  localparam logic [GAIN_W-1:0]  RST_MAX_KP   = GAIN_W'(500);
  localparam logic [GAIN_W-1:0]  RST_MAX_KD   = GAIN_W'(400);
  localparam logic [ERR_W-1:0]   RST_OSC_THR  = ERR_W'(50);
  localparam logic [GAIN_W-1:0]  RST_BASE_KP  = GAIN_W'(50);
  localparam logic [GAIN_W-1:0]  RST_BASE_KD  = GAIN_W'(80);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_AMP = 3'd0,
    CFG_WAIT     = 3'd1,
    CFG_MAX_KP   = 3'd2,
    CFG_MAX_KD   = 3'd3,
    CFG_OSC_THR  = 3'd4,
    CFG_BASE_KP  = 3'd5,
    CFG_BASE_KD  = 3'd6
  } cfg_idx_t;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b0_0000_0001,
    PH_INIT     = 9'b0_0000_0010,
    PH_MOVE_POS = 9'b0_0000_0100,
    PH_WAIT_POS = 9'b0_0000_1000,
    PH_MOVE_NEG = 9'b0_0001_0000,
    PH_WAIT_NEG = 9'b0_0010_0000,
    PH_EVAL     = 9'b0_0100_0000,
    PH_COMPLETE = 9'b0_1000_0000,
    PH_FAILED   = 9'b1_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_COMPLETE = 2'd2,
    ST_FAILED   = 2'd3
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic                     mode_request;
    logic                     goal_valid;
    logic signed [POS_W-1:0]  goal_position;
    logic                     gains_valid;
    logic                     baseline_applied;
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        kd;
    logic [ERR_W-1:0]         peak_error;
  } result_t;

  // magnitude of a two's complement word, clipped to the 31-bit range
  function automatic logic [ERR_W-1:0] abs_sat(input logic [POS_W-1:0] v);
    logic [POS_W-1:0] neg;
    neg = -v;
    if (!v[POS_W-1]) begin
      return v[ERR_W-1:0];
    end else if (neg[POS_W-1]) begin
      return ERR_MAX;
    end else begin
      return neg[ERR_W-1:0];
    end
  endfunction

  function automatic logic [GAIN_W-1:0] gain_add(input logic [GAIN_W-1:0] g,
                                                 input logic [GAIN_W-1:0] d);
    logic [GAIN_W:0] sum;
    sum = {1'b0, g} + {1'b0, d};
    return sum[GAIN_W] ? GAIN_MAX : sum[GAIN_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/sgat_in_if.sv]
// ----------------------------------------------------------------------------
// sgat_in_if
// Request channel into the auto-tuner: start command or control tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgat_in_if;
  import sgat_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    func;
  logic                    fault;
  logic signed [POS_W-1:0] real_position;
  logic signed [POS_W-1:0] pos_error;
  logic signed [POS_W-1:0] vel_error;

  modport source (
    output valid, func, fault, real_position, pos_error, vel_error,
    input  ready
  );

  modport sink (
    input  valid, func, fault, real_position, pos_error, vel_error,
    output ready
  );
endinterface

`default_nettype wire

[hdl/sgat_out_if.sv]
// ----------------------------------------------------------------------------
// sgat_out_if
// Result channel out of the auto-tuner: status, target and gains.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgat_out_if;
  import sgat_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic                    mode_request;
  logic                    goal_valid;
  logic signed [POS_W-1:0] goal_position;
  logic                    gains_valid;
  logic                    baseline_applied;
  logic [GAIN_W-1:0]       kp_out;
  logic [GAIN_W-1:0]       kd_out;
  logic [ERR_W-1:0]        peak_error;

  modport source (
    output valid, status, mode_request, goal_valid, goal_position, gains_valid,
           baseline_applied, kp_out, kd_out, peak_error,
    input  ready
  );

  modport sink (
    input  valid, status, mode_request, goal_valid, goal_position, gains_valid,
           baseline_applied, kp_out, kd_out, peak_error,
    output ready
  );
endinterface

`default_nettype wire

[hdl/sgat_cfg_if.sv]
// ----------------------------------------------------------------------------
// sgat_cfg_if
// Register write channel of the auto-tuner.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgat_cfg_if;
  import sgat_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

[hdl/servo_gain_autotune_fsm.sv]
// ----------------------------------------------------------------------------
// servo_gain_autotune_fsm
// Step-response KP/KD auto-tuner for a position servo.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one request per control tick (func 0) or a start command (func 1),
//            with fault flag, measured position and position/velocity errors.
//   out_if : exactly one result per request: status, mode request, new target
//            position with its valid flag, gains with their valid flag and the
//            peak position error of the last positive wait.
//   cfg_if : register writes, always ready; write only while no request is
//            in flight. Indexes beyond the register list are dropped.
// Pipeline: a request is registered in the input register and its result in
//   the result register. Throughput: one request per cycle unless the output
//   stalls; the tuning state is updated as the request leaves the input
//   register, so the next request sees it in the following cycle.
// Reset (rst_n low, synchronous): phase idle, gains, timer, origin and peak
//   cleared, registers to their default values, both stages emptied.
// Stall: while out_if.ready is low the result holds; one more request is
//   taken into the input register, then in_if.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "servo_gain_autotune_fsm_defines.svh"

module servo_gain_autotune_fsm (
  input  wire logic clk,
  input  wire logic rst_n,
  sgat_in_if.sink   in_if,
  sgat_out_if.source out_if,
  sgat_cfg_if.sink  cfg_if
);
  import sgat_pkg::*;

  // configuration registers
  logic [POS_W-1:0]   step_amp_r;
  logic [TIMER_W-1:0] wait_cycles_r;
  logic [GAIN_W-1:0]  max_kp_r;
  logic [GAIN_W-1:0]  max_kd_r;
  logic [ERR_W-1:0]   osc_thr_r;
  logic [GAIN_W-1:0]  base_kp_r;
  logic [GAIN_W-1:0]  base_kd_r;

  // input register
  logic             s1_vld_r;
  logic             s1_func_r;
  logic             s1_fault_r;
  logic [POS_W-1:0] s1_pos_r;
  logic [POS_W-1:0] s1_perr_r;
  logic [POS_W-1:0] s1_verr_r;

  // tuning state
  phase_t             phase_r, phase_nxt, phase_cur;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [POS_W-1:0]   origin_r, origin_nxt;
  logic [ERR_W-1:0]   max_err_r, max_err_nxt;
  logic               osc_r, osc_nxt;
  logic [GAIN_W-1:0]  kp_r, kp_nxt;
  logic [GAIN_W-1:0]  kd_r, kd_nxt;

  // result register
  logic    out_vld_r;
  result_t res_r, res_nxt;

  logic               s1_adv;
  logic               in_acc;
  logic [ERR_W-1:0]   abs_perr;
  logic [ERR_W-1:0]   abs_verr;
  logic [TIMER_W-1:0] timer_inc;
  logic               timer_done;
  logic               late_wait;

  assign s1_adv      = s1_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !s1_vld_r || s1_adv;
  assign in_acc      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign abs_perr   = abs_sat(s1_perr_r);
  assign abs_verr   = abs_sat(s1_verr_r);
  assign timer_inc  = (timer_r != TIMER_MAX) ? timer_r + TIMER_W'(1) : timer_r;
  assign timer_done = (timer_inc >= wait_cycles_r) || (timer_inc == TIMER_MAX);
  assign late_wait  = timer_inc > {1'b0, wait_cycles_r[TIMER_W-1:1]};
  // a fault on a tick overrides whatever phase we are in
  assign phase_cur  = s1_fault_r ? PH_FAILED : phase_r;

  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    origin_nxt  = origin_r;
    max_err_nxt = max_err_r;
    osc_nxt     = osc_r;
    kp_nxt      = kp_r;
    kd_nxt      = kd_r;
    res_nxt.mode_request     = 1'b0;
    res_nxt.goal_valid       = 1'b0;
    res_nxt.goal_position    = '0;
    res_nxt.gains_valid      = 1'b0;
    res_nxt.baseline_applied = 1'b0;

    if (s1_func_r) begin
      phase_nxt = PH_INIT;
      timer_nxt = '0;
      osc_nxt   = 1'b0;
      res_nxt.mode_request = 1'b1;
    end else begin
      phase_nxt = phase_cur;
      unique case (phase_cur)
        PH_INIT: begin
          kp_nxt     = base_kp_r;
          kd_nxt     = base_kd_r;
          origin_nxt = s1_pos_r;
          timer_nxt  = '0;
          phase_nxt  = PH_MOVE_POS;
          res_nxt.gains_valid      = 1'b1;
          res_nxt.baseline_applied = 1'b1;
          res_nxt.goal_valid       = 1'b1;
          res_nxt.goal_position    = s1_pos_r;
        end
        PH_MOVE_POS: begin
          max_err_nxt = '0;
          timer_nxt   = '0;
          phase_nxt   = PH_WAIT_POS;
          res_nxt.goal_valid    = 1'b1;
          res_nxt.goal_position = origin_r + step_amp_r;
        end
        PH_WAIT_POS: begin
          timer_nxt = timer_inc;
          if (abs_perr > max_err_r) begin
            max_err_nxt = abs_perr;
          end
          if (late_wait && (abs_perr > osc_thr_r) && (abs_verr > osc_thr_r)) begin
            osc_nxt = 1'b1;
          end
          if (timer_done) begin
            phase_nxt = PH_MOVE_NEG;
          end
        end
        PH_MOVE_NEG: begin
          timer_nxt = '0;
          phase_nxt = PH_WAIT_NEG;
          res_nxt.goal_valid    = 1'b1;
          res_nxt.goal_position = origin_r;
        end
        PH_WAIT_NEG: begin
          timer_nxt = timer_inc;
          if (timer_done) begin
            phase_nxt = PH_EVAL;
          end
        end
        PH_EVAL: begin
          if (osc_r) begin
            res_nxt.gains_valid = 1'b1;
            if (kd_r < max_kd_r) begin
              kd_nxt    = gain_add(kd_r, KD_STEP_OSC);
              osc_nxt   = 1'b0;
              phase_nxt = PH_MOVE_POS;
            end else begin
              // derivative at its limit: back off KP and finish
              if (kp_r > KP_BACKOFF) begin
                kp_nxt = kp_r - KP_BACKOFF;
              end
              phase_nxt = PH_COMPLETE;
            end
          end else if (kp_r < max_kp_r) begin
            res_nxt.gains_valid = 1'b1;
            kp_nxt = gain_add(kp_r, KP_STEP);
            if (kd_r < max_kd_r) begin
              kd_nxt = gain_add(kd_r, KD_STEP_UP);
            end
            phase_nxt = PH_MOVE_POS;
          end else begin
            phase_nxt = PH_COMPLETE;
          end
        end
        PH_IDLE, PH_COMPLETE, PH_FAILED: begin
        end
        default: begin
        end
      endcase
    end

    if (phase_nxt == PH_IDLE) begin
      res_nxt.status = ST_IDLE;
    end else if (phase_nxt == PH_COMPLETE) begin
      res_nxt.status = ST_COMPLETE;
    end else if (phase_nxt == PH_FAILED) begin
      res_nxt.status = ST_FAILED;
    end else begin
      res_nxt.status = ST_RUNNING;
    end
    res_nxt.kp         = kp_nxt;
    res_nxt.kd         = kd_nxt;
    res_nxt.peak_error = max_err_nxt;
  end

  // control state, tuning state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      phase_r       <= PH_IDLE;
      timer_r       <= '0;
      origin_r      <= '0;
      max_err_r     <= '0;
      osc_r         <= 1'b0;
      kp_r          <= '0;
      kd_r          <= '0;
      step_amp_r    <= RST_STEP_AMP;
      wait_cycles_r <= RST_WAIT;
      max_kp_r      <= RST_MAX_KP;
      max_kd_r      <= RST_MAX_KD;
      osc_thr_r     <= RST_OSC_THR;
      base_kp_r     <= RST_BASE_KP;
      base_kd_r     <= RST_BASE_KD;
    end else begin
      s1_vld_r  <= in_acc || (s1_vld_r && !s1_adv);
      out_vld_r <= s1_adv || (out_vld_r && !out_if.ready);
      if (s1_adv) begin
        phase_r   <= phase_nxt;
        timer_r   <= timer_nxt;
        origin_r  <= origin_nxt;
        max_err_r <= max_err_nxt;
        osc_r     <= osc_nxt;
        kp_r      <= kp_nxt;
        kd_r      <= kd_nxt;
      end
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          CFG_STEP_AMP: step_amp_r    <= cfg_if.data;
          CFG_WAIT:     wait_cycles_r <= cfg_if.data[TIMER_W-1:0];
          CFG_MAX_KP:   max_kp_r      <= cfg_if.data[GAIN_W-1:0];
          CFG_MAX_KD:   max_kd_r      <= cfg_if.data[GAIN_W-1:0];
          CFG_OSC_THR:  osc_thr_r     <= cfg_if.data[ERR_W-1:0];
          CFG_BASE_KP:  base_kp_r     <= cfg_if.data[GAIN_W-1:0];
          CFG_BASE_KD:  base_kd_r     <= cfg_if.data[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= in_if.func;
      s1_fault_r <= in_if.fault;
      s1_pos_r   <= in_if.real_position;
      s1_perr_r  <= in_if.pos_error;
      s1_verr_r  <= in_if.vel_error;
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid            = out_vld_r;
  assign out_if.status           = res_r.status;
  assign out_if.mode_request     = res_r.mode_request;
  assign out_if.goal_valid       = res_r.goal_valid;
  assign out_if.goal_position    = res_r.goal_position;
  assign out_if.gains_valid      = res_r.gains_valid;
  assign out_if.baseline_applied = res_r.baseline_applied;
  assign out_if.kp_out           = res_r.kp;
  assign out_if.kd_out           = res_r.kd;
  assign out_if.peak_error       = res_r.peak_error;

  `SGAT_ASSERT_NEXT(a_start_enters_init, clk, rst_n, s1_adv && s1_func_r, phase_r == PH_INIT)
  `SGAT_ASSERT_NEXT(a_stall_holds_state, clk, rst_n, out_vld_r && !out_if.ready, $stable(kp_r) && $stable(phase_r))
  `SGAT_ASSERT_NOW(a_gains_not_idle, clk, rst_n, out_vld_r && res_r.gains_valid, res_r.status != ST_IDLE)
  `SGAT_ASSERT_NOW(a_baseline_writes_all, clk, rst_n, out_vld_r && res_r.baseline_applied, res_r.gains_valid && res_r.goal_valid)

endmodule

`default_nettype wire
